@@ rtl/grd_pkg.sv @@
// grd_pkg: types, constants and small decode functions for the gamepad report decoder
// depends on nothing; used by the channel interfaces and gamepad_report_decoder
package grd_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int BUTTONS_W = 18;
   localparam int AXIS_W    = 8;
   localparam int MASK_W    = 3;
   localparam int BATT_W    = 7;
   localparam int COUNT_W   = 4;
   localparam int RAW_AXIS_W = 12;

   // report layout
   localparam int BUF_LEN        = 13;
   localparam logic [COUNT_W-1:0] COUNT_MAX      = 4'd15;
   localparam logic [COUNT_W-1:0] MIN_LEN_FULL   = 4'd13;
   localparam logic [COUNT_W-1:0] MIN_LEN_SIMPLE = 4'd12;
   localparam logic [BYTE_W-1:0]  ID_FULL        = 8'h30;
   localparam logic [BYTE_W-1:0]  ID_SIMPLE      = 8'h3F;
   localparam int DPAD_LSB    = 14;
   localparam int CHARGE_BIT  = 3;

   // report kind codes
   localparam logic KIND_FULL   = 1'b0;
   localparam logic KIND_SIMPLE = 1'b1;

   // hat switch codes, clockwise from up
   localparam logic [BYTE_W-1:0] HAT_N  = 8'd0;
   localparam logic [BYTE_W-1:0] HAT_NE = 8'd1;
   localparam logic [BYTE_W-1:0] HAT_E  = 8'd2;
   localparam logic [BYTE_W-1:0] HAT_SE = 8'd3;
   localparam logic [BYTE_W-1:0] HAT_S  = 8'd4;
   localparam logic [BYTE_W-1:0] HAT_SW = 8'd5;
   localparam logic [BYTE_W-1:0] HAT_W  = 8'd6;
   localparam logic [BYTE_W-1:0] HAT_NW = 8'd7;

   // valid mask codes
   localparam logic [MASK_W-1:0] MASK_ALL        = 3'b000;
   localparam logic [MASK_W-1:0] MASK_LEFT_GRIP  = 3'b011;
   localparam logic [MASK_W-1:0] MASK_RIGHT_GRIP = 3'b101;

   // axis scaling 12 -> 8 bits
   localparam int SCALE_MUL = 254;
   localparam int SCALE_DIV = 4095;
   localparam int PROD_W    = 20;

   // battery
   localparam logic [BATT_W-1:0] BATT_MAX  = 7'd100;
   localparam logic [BATT_W-1:0] BATT_STEP = 7'd12;
   localparam logic [BATT_W-1:0] BATT_BASE = 7'd5;
   localparam logic [3:0]        BATT_SAT_NIBBLE = 4'd8;

   typedef enum logic [1:0] {
      GRIP_LEFT      = 2'd0,
      GRIP_RIGHT     = 2'd1,
      GRIP_UNDECIDED = 2'd2
   } grip_type;

   typedef struct packed {
      logic [BUTTONS_W-1:0] buttons;
      logic [AXIS_W-1:0]    left_x;
      logic [AXIS_W-1:0]    left_y;
      logic [AXIS_W-1:0]    right_x;
      logic [AXIS_W-1:0]    right_y;
      logic [MASK_W-1:0]    valid_mask;
      logic [BATT_W-1:0]    battery_percent;
      logic                 charging;
      logic                 report_kind;
   } rsp_type;

   // 1 + floor(v*254/4095); 4095 = 2^12-1 so the quotient is p>>12 plus one correction
   function automatic logic [AXIS_W-1:0] scale12(input logic [RAW_AXIS_W-1:0] v);
      logic [PROD_W-1:0]       p;
      logic [AXIS_W-1:0]       q0;
      logic [RAW_AXIS_W:0]     r;
      logic                    fix;
      p   = PROD_W'(v) * PROD_W'(SCALE_MUL);
      q0  = p[PROD_W-1:RAW_AXIS_W];
      r   = {1'b0, p[RAW_AXIS_W-1:0]} + (RAW_AXIS_W+1)'(q0);
      fix = (r >= (RAW_AXIS_W+1)'(SCALE_DIV));
      return AXIS_W'(9'd1 + {1'b0, q0} + 9'(fix));
   endfunction

   // nibble*12+5, saturated at 100
   function automatic logic [BATT_W-1:0] batt_from_nibble(input logic [3:0] nib);
      logic [BATT_W-1:0] lvl;
      if (nib >= BATT_SAT_NIBBLE) begin
         lvl = BATT_MAX;
      end else begin
         lvl = BATT_W'({3'b000, nib} * BATT_STEP) + BATT_BASE;
      end
      return lvl;
   endfunction

endpackage

@@ rtl/grd_req_if.sv @@
// grd_req_if: valid/ready channel carrying report bytes into the decoder
// depends on grd_pkg for field widths
interface grd_req_if;
   logic                       valid;
   logic                       ready;
   logic [grd_pkg::BYTE_W-1:0] report_byte;
   logic                       last_byte;

   modport source (output valid, output report_byte, output last_byte, input ready);
   modport sink   (input valid, input report_byte, input last_byte, output ready);
endinterface

@@ rtl/grd_rsp_if.sv @@
// grd_rsp_if: valid/ready channel carrying decoded gamepad state out of the decoder
// depends on grd_pkg for field widths
interface grd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [grd_pkg::BUTTONS_W-1:0] buttons;
   logic [grd_pkg::AXIS_W-1:0]    left_x;
   logic [grd_pkg::AXIS_W-1:0]    left_y;
   logic [grd_pkg::AXIS_W-1:0]    right_x;
   logic [grd_pkg::AXIS_W-1:0]    right_y;
   logic [grd_pkg::MASK_W-1:0]    valid_mask;
   logic [grd_pkg::BATT_W-1:0]    battery_percent;
   logic                          charging;
   logic                          report_kind;

   modport source (output valid, output buttons, output left_x, output left_y,
                   output right_x, output right_y, output valid_mask,
                   output battery_percent, output charging, output report_kind,
                   input ready);
   modport sink   (input valid, input buttons, input left_x, input left_y,
                   input right_x, input right_y, input valid_mask,
                   input battery_percent, input charging, input report_kind,
                   output ready);
endinterface

@@ rtl/gamepad_report_decoder.sv @@
// gamepad_report_decoder: byte-serial gamepad input report decoder, top level
// depends on grd_pkg, grd_req_if and grd_rsp_if
//
// usage
// - req_chan takes one report byte per item, last_byte high on the final byte
// - rsp_chan gives one decoded item per recognized report: full layout (id 0x30,
//   13+ bytes) or simple layout (id 0x3F, 12+ bytes); other reports give nothing
// - one byte per cycle while no last byte waits for the output register; a byte is
//   held in the input register and decoded from there, and its result is held in
//   the output register, which drives rsp_chan
// - the decode is a single pass of shallow logic: four constant-multiply axis
//   scalers, battery lookup and button remap, between input and result registers
// - a result waiting in the output register does not block bytes of the next
//   report; only a last byte waits for the output register to be free
// - when the receiver stalls, rsp payload holds until taken; req_chan.ready
//   drops only while a last byte is held and the output register is still full
// - reset (synchronous, active high) clears the byte count, grip side
//   (undecided), held battery and charging state and both valid flags; the
//   report buffer is not cleared, only bytes of the current report are read
// - grip side is detected once, from the first decoded report where exactly one
//   stick rests at zero, and then chooses the valid mask
module gamepad_report_decoder (
   input  logic         clock,
   input  logic         reset,
   grd_req_if.sink      req_chan,
   grd_rsp_if.source    rsp_chan
);

   // input register
   logic                       s0_valid_ff, s0_valid_in;
   logic [grd_pkg::BYTE_W-1:0] s0_byte_ff;
   logic                       s0_last_ff;

   // report state
   logic [grd_pkg::BYTE_W-1:0]  buf_ff [grd_pkg::BUF_LEN];
   logic [grd_pkg::COUNT_W-1:0] count_ff, count_in;
   grd_pkg::grip_type           grip_ff, grip_in;
   logic [grd_pkg::BATT_W-1:0]  batt_ff, batt_in;
   logic                        chg_ff, chg_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   grd_pkg::rsp_type     rsp_ff, rsp_in;

   logic out_free;
   logic advance;
   logic report_end;

   // decode signals
   logic [grd_pkg::BYTE_W-1:0]  cur [grd_pkg::BUF_LEN];
   logic [grd_pkg::COUNT_W-1:0] len;
   logic                        hit_full, hit_simple, hit;
   logic [grd_pkg::BUTTONS_W-1:0] btn_full, btn_simple, btn_sel;
   logic [grd_pkg::RAW_AXIS_W-1:0] lx_raw, ly_raw, rx_raw, ry_raw;
   logic [grd_pkg::AXIS_W-1:0]  lx_full, ly_full, rx_full, ry_full;
   logic                        l_empty, r_empty;
   logic [grd_pkg::BYTE_W-1:0]  hat;
   logic [grd_pkg::BATT_W-1:0]  batt_new;
   logic [grd_pkg::MASK_W-1:0]  mask_sel;

   // handshake: a last byte needs room in the output register, other bytes never wait
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s0_valid_ff && (!s0_last_ff || out_free);
   assign report_end     = advance && s0_last_ff;
   assign req_chan.ready = !s0_valid_ff || advance;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (advance) begin
         s0_valid_in = 1'b0;
      end
      if (req_chan.valid && req_chan.ready) begin
         s0_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s0_byte_ff <= req_chan.report_byte;
         s0_last_ff <= req_chan.last_byte;
      end
   end

   // buffer view with the byte in flight merged at its slot
   always_comb begin
      for (int i = 0; i < grd_pkg::BUF_LEN; i++) begin
         cur[i] = (count_ff == grd_pkg::COUNT_W'(i)) ? s0_byte_ff : buf_ff[i];
      end
   end

   // saturating length including this byte
   assign len = (count_ff == grd_pkg::COUNT_MAX) ? grd_pkg::COUNT_MAX : count_ff + 4'd1;

   assign hit_full   = (cur[0] == grd_pkg::ID_FULL)   && (len >= grd_pkg::MIN_LEN_FULL);
   assign hit_simple = (cur[0] == grd_pkg::ID_SIMPLE) && (len >= grd_pkg::MIN_LEN_SIMPLE);
   assign hit        = hit_full || hit_simple;

   // full layout: bytes 3..5 are right, shared and left button groups
   assign btn_full = {cur[5][2], cur[5][3], cur[5][0], cur[5][1],
                      cur[4][5], cur[4][4], cur[4][2], cur[4][3], cur[4][1], cur[4][0],
                      cur[3][7], cur[5][7], cur[3][6], cur[5][6],
                      cur[3][1], cur[3][0], cur[3][3], cur[3][2]};

   // simple layout: hat switch drives the d-pad bits
   assign hat = cur[3];
   assign btn_simple[13:0] = {cur[2][5:0], cur[1]};
   assign btn_simple[14] = (hat == grd_pkg::HAT_N)  || (hat == grd_pkg::HAT_NE) ||
                           (hat == grd_pkg::HAT_NW);
   assign btn_simple[15] = (hat == grd_pkg::HAT_SE) || (hat == grd_pkg::HAT_S) ||
                           (hat == grd_pkg::HAT_SW);
   assign btn_simple[16] = (hat == grd_pkg::HAT_SW) || (hat == grd_pkg::HAT_W) ||
                           (hat == grd_pkg::HAT_NW);
   assign btn_simple[17] = (hat == grd_pkg::HAT_NE) || (hat == grd_pkg::HAT_E) ||
                           (hat == grd_pkg::HAT_SE);

   // right-grip devices lose the d-pad, judged by the side held before this report
   always_comb begin
      btn_sel = hit_full ? btn_full : btn_simple;
      if (grip_ff == grd_pkg::GRIP_RIGHT) begin
         btn_sel[grd_pkg::BUTTONS_W-1:grd_pkg::DPAD_LSB] = '0;
      end
   end

   // 12-bit packed sticks of the full layout
   assign lx_raw = {cur[7][3:0], cur[6]};
   assign ly_raw = {cur[8], cur[7][7:4]};
   assign rx_raw = {cur[10][3:0], cur[9]};
   assign ry_raw = {cur[11], cur[10][7:4]};

   assign lx_full = grd_pkg::scale12(lx_raw);
   assign ly_full = grd_pkg::scale12(ly_raw);
   assign rx_full = grd_pkg::scale12(rx_raw);
   assign ry_full = grd_pkg::scale12(ry_raw);

   // a stick at rest reads all zero in either layout (simple: bytes 4..7, 8..11; full: 6..8, 9..11)
   assign l_empty = (cur[4] == '0 && cur[5] == '0 && cur[6] == '0 && cur[7] == '0)
                    && hit_simple
                 || (lx_raw == '0 && ly_raw == '0) && hit_full;
   assign r_empty = (cur[8] == '0 && cur[9] == '0 && cur[10] == '0 && cur[11] == '0)
                    && hit_simple
                 || (rx_raw == '0 && ry_raw == '0) && hit_full;

   assign batt_new = grd_pkg::batt_from_nibble(cur[2][7:4]);

   // grip side detector, next state
   always_comb begin
      grip_in = grip_ff;
      if (report_end && hit) begin
         case (grip_ff)
            grd_pkg::GRIP_LEFT,
            grd_pkg::GRIP_RIGHT: grip_in = grip_ff;
            default: begin
               if (r_empty && !l_empty) begin
                  grip_in = grd_pkg::GRIP_LEFT;
               end else if (l_empty && !r_empty) begin
                  grip_in = grd_pkg::GRIP_RIGHT;
               end
            end
         endcase
      end
   end

   // grip side detector, mask output from the updated side
   always_comb begin
      case (grip_in)
         grd_pkg::GRIP_LEFT:  mask_sel = grd_pkg::MASK_LEFT_GRIP;
         grd_pkg::GRIP_RIGHT: mask_sel = grd_pkg::MASK_RIGHT_GRIP;
         default:             mask_sel = grd_pkg::MASK_ALL;
      endcase
   end

   // byte count, held battery and held charging state
   always_comb begin
      count_in = count_ff;
      batt_in  = batt_ff;
      chg_in   = chg_ff;
      if (advance) begin
         count_in = s0_last_ff ? '0 : len;
      end
      if (report_end && hit_full) begin
         batt_in = batt_new;
         chg_in  = cur[2][grd_pkg::CHARGE_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         grip_ff  <= grd_pkg::GRIP_UNDECIDED;
         batt_ff  <= '0;
         chg_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         grip_ff  <= grip_in;
         batt_ff  <= batt_in;
         chg_ff   <= chg_in;
      end
   end

   // bytes past the buffer are counted but not kept
   always_ff @(posedge clock) begin
      if (advance && (count_ff < grd_pkg::COUNT_W'(grd_pkg::BUF_LEN))) begin
         buf_ff[count_ff] <= s0_byte_ff;
      end
   end

   // result assembly
   always_comb begin
      rsp_in.buttons    = btn_sel;
      rsp_in.valid_mask = mask_sel;
      if (hit_full) begin
         rsp_in.left_x          = lx_full;
         rsp_in.left_y          = ~ly_full;
         rsp_in.right_x         = rx_full;
         rsp_in.right_y         = ~ry_full;
         rsp_in.battery_percent = batt_new;
         rsp_in.charging        = cur[2][grd_pkg::CHARGE_BIT];
         rsp_in.report_kind     = grd_pkg::KIND_FULL;
      end else begin
         // simple layout keeps the high byte of each 16-bit axis
         rsp_in.left_x          = cur[5];
         rsp_in.left_y          = ~cur[7];
         rsp_in.right_x         = cur[9];
         rsp_in.right_y         = ~cur[11];
         rsp_in.battery_percent = batt_ff;
         rsp_in.charging        = chg_ff;
         rsp_in.report_kind     = grd_pkg::KIND_SIMPLE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (report_end && hit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report_end && hit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.buttons         = rsp_ff.buttons;
   assign rsp_chan.left_x          = rsp_ff.left_x;
   assign rsp_chan.left_y          = rsp_ff.left_y;
   assign rsp_chan.right_x         = rsp_ff.right_x;
   assign rsp_chan.right_y         = rsp_ff.right_y;
   assign rsp_chan.valid_mask      = rsp_ff.valid_mask;
   assign rsp_chan.battery_percent = rsp_ff.battery_percent;
   assign rsp_chan.charging        = rsp_ff.charging;
   assign rsp_chan.report_kind     = rsp_ff.report_kind;

   // once a side is decided it never changes
   a_grip_sticky: assert property (@(posedge clock) disable iff (reset)
      (grip_ff != grd_pkg::GRIP_UNDECIDED) |=> (grip_ff == $past(grip_ff)))
      else $error("grip side changed after detection");

   // the end of a report always restarts the byte count
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      report_end |=> (count_ff == '0))
      else $error("byte count not cleared at end of report");

   // a shown result carries one of the three mask codes
   a_mask_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.valid_mask == grd_pkg::MASK_ALL ||
                        rsp_ff.valid_mask == grd_pkg::MASK_LEFT_GRIP ||
                        rsp_ff.valid_mask == grd_pkg::MASK_RIGHT_GRIP))
      else $error("bad valid mask on result");

   // held battery level stays within percent range
   a_batt_range: assert property (@(posedge clock) disable iff (reset)
      batt_ff <= grd_pkg::BATT_MAX)
      else $error("held battery above 100");

endmodule
